// ----- rtl/nsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nsd_pkg;

  // shown digit positions (1 to 8)
  localparam int DIGITS = 4;

  localparam int VALUE_W  = 16;
  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int MAX_DIG  = 16;
  localparam int LEN_W    = $clog2(MAX_DIG + 1);
  localparam int CNT_W    = $clog2(VALUE_W);
  localparam int GRID_CNT = 4;
  localparam int SEG_W    = 8;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
  localparam logic [SEG_W-1:0]   LED_GRID    = 8'h0F;
  localparam logic [SEG_W-1:0]   UNUSED_GRID = 8'h00;
  localparam logic [SEG_W-1:0]   BLANK_SEG   = 8'h00;

  // register word index (paddr[2])
  localparam logic REG_RADIX = 1'b0;

  typedef logic [MAX_DIG-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    digits_t          digits;
    logic [LEN_W-1:0] len;
  } conv_res_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    e = r;
    if (r < RADIX_MIN) e = RADIX_MIN;
    if (r > RADIX_MAX) e = RADIX_MAX;
    return e;
  endfunction

  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/nsd_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nsd_conv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [nsd_pkg::VALUE_W-1:0]   value,
  input  wire logic [nsd_pkg::RADIX_W-1:0]   radix,
  output logic                               busy,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output nsd_pkg::conv_res_t                 res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam int MD = nsd_pkg::MAX_DIG;

  state_t                           state_r, state_nxt;
  logic [nsd_pkg::VALUE_W-1:0]      bits_r;
  logic [nsd_pkg::RADIX_W-1:0]      radix_r;
  nsd_pkg::digits_t                 digits_r, digits_nxt;
  logic [nsd_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [nsd_pkg::CNT_W-1:0]        cnt_r;

  logic              bit_in;
  logic [MD-1:0]     gen, prop, opa;
  logic [MD:0]       sum, cin;
  logic [nsd_pkg::RADIX_W-1:0] t;

  assign bit_in = bits_r[nsd_pkg::VALUE_W-1];

  // doubling all digits in the radix: carries resolve like an adder chain
  always_comb begin
    for (int i = 0; i < MD; i++) begin
      gen[i]  = ({digits_r[i], 1'b0} >= radix_r);
      prop[i] = ({digits_r[i], 1'b1} == radix_r);
    end
    opa = gen | prop;
    sum = {1'b0, opa} + {1'b0, gen} + (MD+1)'(bit_in);
    cin = sum ^ {1'b0, opa} ^ {1'b0, gen};
    for (int i = 0; i < MD; i++) begin
      t = {digits_r[i], cin[i]};
      if (cin[i+1]) t = t - radix_r;
      digits_nxt[i] = t[nsd_pkg::DIGIT_W-1:0];
    end
    // the digit just above the top gets at most the carry
    len_nxt = len_r + nsd_pkg::LEN_W'(cin[len_r]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == nsd_pkg::CNT_W'(nsd_pkg::VALUE_W - 1)) state_nxt = ST_DONE;
      ST_DONE: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RUN) cnt_r <= cnt_r + 1'b1;
      else cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      bits_r   <= value;
      radix_r  <= nsd_pkg::eff_radix(radix);
      digits_r <= '0;
      len_r    <= '0;
    end else if (state_r == ST_RUN) begin
      bits_r   <= {bits_r[nsd_pkg::VALUE_W-2:0], 1'b0};
      digits_r <= digits_nxt;
      len_r    <= len_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign res_valid  = (state_r == ST_DONE);
  assign res.digits = digits_r;
  assign res.len    = len_r;

endmodule
`default_nettype wire

// ----- rtl/nsd_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nsd_out (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        res_valid,
  output logic                             res_ready,
  input  wire nsd_pkg::conv_res_t          res,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [nsd_pkg::SEG_W-1:0]        out_grid_one,
  output logic [nsd_pkg::SEG_W-1:0]        out_grid_two,
  output logic [nsd_pkg::SEG_W-1:0]        out_grid_three,
  output logic [nsd_pkg::SEG_W-1:0]        out_grid_four,
  output logic [nsd_pkg::SEG_W-1:0]        out_grid_five,
  output logic [nsd_pkg::SEG_W-1:0]        out_grid_six
);

  localparam int W  = (nsd_pkg::DIGITS < 1) ? 1 :
                      (nsd_pkg::DIGITS > 8) ? 8 : nsd_pkg::DIGITS;
  localparam int LW = nsd_pkg::LEN_W;

  logic                       valid_r;
  logic [nsd_pkg::SEG_W-1:0]  grid_r [nsd_pkg::GRID_CNT];
  logic [nsd_pkg::SEG_W-1:0]  grid_nxt [nsd_pkg::GRID_CNT];
  logic [LW-1:0]              count, top, idx;
  int                         p;

  // leftmost shown digit sits at index top, blank where above the number
  always_comb begin
    count = (res.len == '0) ? LW'(1) : res.len;
    top   = ((count > LW'(W)) ? count : LW'(W)) - LW'(1);
    idx   = '0;
    p     = 0;
    for (int g = 0; g < nsd_pkg::GRID_CNT; g++) begin
      p = W - nsd_pkg::GRID_CNT + g;
      grid_nxt[g] = nsd_pkg::BLANK_SEG;
      if (p >= 0) begin
        idx = top - LW'(p);
        if (idx < count)
          grid_nxt[g] = nsd_pkg::seg_code(res.digits[idx[LW-2:0]]);
      end
    end
  end

  assign res_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      for (int g = 0; g < nsd_pkg::GRID_CNT; g++) grid_r[g] <= grid_nxt[g];
    end
  end

  assign out_valid      = valid_r;
  assign out_grid_one   = grid_r[0];
  assign out_grid_two   = grid_r[1];
  assign out_grid_three = grid_r[3];
  assign out_grid_four  = nsd_pkg::UNUSED_GRID;
  assign out_grid_five  = nsd_pkg::LED_GRID;
  assign out_grid_six   = grid_r[2];

endmodule
`default_nettype wire

// ----- rtl/number_to_segment_digits.sv -----
// conversion: the value is fed one bit per cycle through the digit shift chain,
// and the digits are then formatted into the output register that drives out_valid
// throughput: a new input is taken only once the converter is idle again, after
// its result has been taken by the output register
// reset: synchronous active-low rst_n clears control state and sets radix to 10
`timescale 1ns / 1ps
`default_nettype none
module number_to_segment_digits (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nsd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [nsd_pkg::DATA_W-1:0]    pwdata,
  output logic [nsd_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [nsd_pkg::VALUE_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [nsd_pkg::SEG_W-1:0]          out_grid_one,
  output logic [nsd_pkg::SEG_W-1:0]          out_grid_two,
  output logic [nsd_pkg::SEG_W-1:0]          out_grid_three,
  output logic [nsd_pkg::SEG_W-1:0]          out_grid_four,
  output logic [nsd_pkg::SEG_W-1:0]          out_grid_five,
  output logic [nsd_pkg::SEG_W-1:0]          out_grid_six
);

  logic [nsd_pkg::RADIX_W-1:0] radix_r;
  logic                        busy, res_valid, res_ready;
  nsd_pkg::conv_res_t          res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= nsd_pkg::RADIX_RESET;
    end else if (psel && penable && pwrite && paddr[2] == nsd_pkg::REG_RADIX) begin
      radix_r <= pwdata[nsd_pkg::RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == nsd_pkg::REG_RADIX)
      prdata = {{(nsd_pkg::DATA_W-nsd_pkg::RADIX_W){1'b0}}, radix_r};
  end

  assign in_ready = !busy;

  nsd_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid),
    .value     (in_value),
    .radix     (radix_r),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  nsd_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_grid_one   (out_grid_one),
    .out_grid_two   (out_grid_two),
    .out_grid_three (out_grid_three),
    .out_grid_four  (out_grid_four),
    .out_grid_five  (out_grid_five),
    .out_grid_six   (out_grid_six)
  );

endmodule
`default_nettype wire
